### rtl/core/binned_lut_pixel_enhancer_defines.svh
// Assertion macros used by the checker file.
`ifndef BINNED_LUT_PIXEL_ENHANCER_DEFINES_SVH
`define BINNED_LUT_PIXEL_ENHANCER_DEFINES_SVH

// Same-cycle implication.
`define BLPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BLPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/blpe_pkg.sv
package blpe_pkg;

   localparam int LUT_DEPTH_DEF    = 256;
   localparam int SAMPLE_WIDTH_DEF = 17;

   localparam int SCALE_W   = 24;
   localparam int FRAC_W    = 16;
   localparam int COUNT_W   = 9;
   localparam int INDEX_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CLAMP_MAX = 255;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SCALE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NODATA_VALUE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NODATA_EN    = 3'd5;

   localparam logic MODE_LUT     = 1'b0;
   localparam logic MODE_CLAMP   = 1'b1;
   localparam logic OP_PIXEL     = 1'b0;
   localparam logic OP_LUT_WRITE = 1'b1;

   localparam logic [COUNT_W-1:0] BIN_COUNT_RST = 9'd256;
   localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 24'd65536;

endpackage

### rtl/core/blpe_ram.sv
module blpe_ram #(
   parameter int WIDTH = blpe_pkg::SAMPLE_WIDTH_DEF,
   parameter int DEPTH = blpe_pkg::LUT_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/binned_lut_pixel_enhancer.sv
// Binned look-up-table pixel enhancer for one band of samples.
// req channel: one transfer per item. req_op selects a pixel sample or a
// LUT entry write (req_lut_index, req_lut_value). Writes give no result.
// rsp channel: one transfer per pixel, carrying rsp_pixel_out and
// rsp_end_of_block (a copy of req_last_pixel), in input order.
// csr port: csr_wr_en writes csr_data into register csr_index
// (0 mode, 1 bin_count, 2 range_low, 3 bin_scale, 4 nodata_value,
// 5 nodata_enable); other indexes are dropped. Write only while idle.
// Each pixel is registered in stages A, B and C and then in the output register.
// Throughput: one item per clock while no result stalls, set by the one LUT
// RAM read port that each pixel mapped by the LUT reads once in the third
// stage; writes take the write port in that same stage, keeping input order.
// Stall: while rsp_stall holds a waiting result, the whole pipeline and
// the RAM read data hold and req_stall is raised; no item is lost.
// Reset clears the pipeline valid bits and loads the register defaults;
// the LUT contents stay undefined until written. No clearing pass.
module binned_lut_pixel_enhancer #(
   parameter int LUT_DEPTH    = blpe_pkg::LUT_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = blpe_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_last_pixel,
   input  logic [blpe_pkg::INDEX_W-1:0]        req_lut_index,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_lut_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_pixel_out,
   output logic                                rsp_end_of_block,
   input  logic                                csr_wr_en,
   input  logic [blpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [((SAMPLE_WIDTH > blpe_pkg::SCALE_W) ?
                  SAMPLE_WIDTH : blpe_pkg::SCALE_W)-1:0] csr_data
);

   import blpe_pkg::*;

   localparam int ADDR_W = $clog2(LUT_DEPTH);
   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = DIFF_W + SCALE_W;
   localparam int BIN_W  = PROD_W - FRAC_W;

   logic                           mode_ff;
   logic [COUNT_W-1:0]             bin_count_ff;
   logic signed [SAMPLE_WIDTH-1:0] range_low_ff;
   logic [SCALE_W-1:0]             bin_scale_ff;
   logic signed [SAMPLE_WIDTH-1:0] nodata_value_ff;
   logic                           nodata_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_LUT;
         bin_count_ff    <= BIN_COUNT_RST;
         range_low_ff    <= '0;
         bin_scale_ff    <= BIN_SCALE_RST;
         nodata_value_ff <= '0;
         nodata_en_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:         mode_ff         <= csr_data[0];
            CSR_BIN_COUNT:    bin_count_ff    <= csr_data[COUNT_W-1:0];
            CSR_RANGE_LOW:    range_low_ff    <= csr_data[SAMPLE_WIDTH-1:0];
            CSR_BIN_SCALE:    bin_scale_ff    <= csr_data[SCALE_W-1:0];
            CSR_NODATA_VALUE: nodata_value_ff <= csr_data[SAMPLE_WIDTH-1:0];
            CSR_NODATA_EN:    nodata_en_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic advance;
   logic accept;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   // stage A: classify and clamp the sample and form the offset from range_low
   logic                           nodata;
   logic                           below;
   logic signed [SAMPLE_WIDTH-1:0] clamp_val;
   logic                           a_use_lut_in;
   logic signed [SAMPLE_WIDTH-1:0] a_pass_in;
   logic [DIFF_W-1:0]              a_diff_in;
   logic                           a_wok_in;

   always_comb begin
      nodata = nodata_en_ff && (req_sample == nodata_value_ff);
      below  = req_sample < range_low_ff;
      if (req_sample < 0) begin
         clamp_val = '0;
      end else if (longint'(req_sample) > longint'(CLAMP_MAX)) begin
         clamp_val = SAMPLE_WIDTH'(CLAMP_MAX);
      end else begin
         clamp_val = req_sample;
      end
      a_pass_in    = (mode_ff == MODE_CLAMP && !nodata) ? clamp_val : req_sample;
      a_use_lut_in = (mode_ff == MODE_LUT) && !nodata && !below;
      a_diff_in    = {req_sample[SAMPLE_WIDTH-1], req_sample}
                   - {range_low_ff[SAMPLE_WIDTH-1], range_low_ff};
      a_wok_in     = int'(req_lut_index) < LUT_DEPTH;
   end

   logic                           a_vld_ff, a_op_ff, a_last_ff, a_use_lut_ff, a_wok_ff;
   logic signed [SAMPLE_WIDTH-1:0] a_pass_ff, a_wval_ff;
   logic [DIFF_W-1:0]              a_diff_ff;
   logic [ADDR_W-1:0]              a_widx_ff;

   // stage B: bin number from the Q8.16 scale
   logic [PROD_W-1:0] prod;
   logic [BIN_W-1:0]  b_bin_in;

   assign prod     = a_diff_ff * bin_scale_ff;
   assign b_bin_in = prod[PROD_W-1:FRAC_W];

   logic                           b_vld_ff, b_op_ff, b_last_ff, b_use_lut_ff, b_wok_ff;
   logic signed [SAMPLE_WIDTH-1:0] b_pass_ff, b_wval_ff;
   logic [BIN_W-1:0]               b_bin_ff;
   logic [ADDR_W-1:0]              b_widx_ff;

   // stage C: saturate the bin and access the LUT
   logic [31:0]       count_wide;
   logic [ADDR_W-1:0] last_bin;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic              wr_en;

   always_comb begin
      count_wide = 32'(bin_count_ff);
      if (count_wide == 32'd0) begin
         count_wide = 32'd1;
      end else if (count_wide > 32'(LUT_DEPTH)) begin
         count_wide = 32'(LUT_DEPTH);
      end
      last_bin = ADDR_W'(count_wide - 32'd1);
      if (b_bin_ff > BIN_W'(last_bin)) begin
         rd_addr = last_bin;
      end else begin
         rd_addr = b_bin_ff[ADDR_W-1:0];
      end
      rd_en = advance && b_vld_ff && (b_op_ff == OP_PIXEL) && b_use_lut_ff;
      wr_en = advance && b_vld_ff && (b_op_ff == OP_LUT_WRITE) && b_wok_ff;
   end

   logic [SAMPLE_WIDTH-1:0] ram_rd_data;

   blpe_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (LUT_DEPTH)
   ) u_lut (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_widx_ff),
      .wr_data (b_wval_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   logic                           c_vld_ff, c_op_ff, c_last_ff, c_use_lut_ff;
   logic signed [SAMPLE_WIDTH-1:0] c_pass_ff;

   // output register
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_pixel_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_pixel_ff;
   logic                           rsp_eob_ff;

   assign rsp_valid_in = c_vld_ff && (c_op_ff == OP_PIXEL);
   assign rsp_pixel_in = c_use_lut_ff ? $signed(ram_rd_data) : c_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff     <= accept;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff      <= req_op;
         a_last_ff    <= req_last_pixel;
         a_use_lut_ff <= a_use_lut_in;
         a_pass_ff    <= a_pass_in;
         a_diff_ff    <= a_diff_in;
         a_widx_ff    <= ADDR_W'(req_lut_index);
         a_wval_ff    <= req_lut_value;
         a_wok_ff     <= a_wok_in;

         b_op_ff      <= a_op_ff;
         b_last_ff    <= a_last_ff;
         b_use_lut_ff <= a_use_lut_ff;
         b_pass_ff    <= a_pass_ff;
         b_bin_ff     <= b_bin_in;
         b_widx_ff    <= a_widx_ff;
         b_wval_ff    <= a_wval_ff;
         b_wok_ff     <= a_wok_ff;

         c_op_ff      <= b_op_ff;
         c_last_ff    <= b_last_ff;
         c_use_lut_ff <= b_use_lut_ff;
         c_pass_ff    <= b_pass_ff;

         rsp_pixel_ff <= rsp_pixel_in;
         rsp_eob_ff   <= c_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_end_of_block = rsp_eob_ff;

endmodule

### rtl/core/blpe_checker.sv
`include "binned_lut_pixel_enhancer_defines.svh"

module blpe_checker #(
   parameter int SAMPLE_WIDTH = blpe_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_pixel_out,
   input logic                    rsp_end_of_block
);

   import blpe_pkg::*;

   `BLPE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_end_of_block), "stalled result changed")
   `BLPE_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a held result")
   `BLPE_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && !req_stall, "pipeline not cleared by reset")

endmodule

bind binned_lut_pixel_enhancer blpe_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_blpe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_out    (rsp_pixel_out),
   .rsp_end_of_block (rsp_end_of_block)
);

### sim/tb.sv
`timescale 1ns / 1ps

typedef struct {
   logic                mode;
   logic [8:0]          bin_cnt;
   logic signed [16:0]  low;
   logic [23:0]         scale;
   logic signed [16:0]  nodata;
   logic                nodata_en;
} enh_cfg_type;

typedef struct {
   logic [16:0] pixel;
   logic        eob;
} pixel_result_type;

class enhancer_scoreboard;
   logic               mode;
   logic [8:0]         bin_count;
   logic signed [16:0] range_low;
   logic [23:0]        bin_scale;
   logic signed [16:0] nodata_value;
   logic               nodata_en;
   logic signed [16:0] lut_mem [256];
   pixel_result_type   pending_pixels[$];
   int                 fault_count;

   function new();
      mode         = blpe_pkg::MODE_LUT;
      bin_count    = blpe_pkg::BIN_COUNT_RST;
      range_low    = '0;
      bin_scale    = blpe_pkg::BIN_SCALE_RST;
      nodata_value = '0;
      nodata_en    = 1'b0;
      fault_count  = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
         blpe_pkg::CSR_MODE:         mode = data[0];
         blpe_pkg::CSR_BIN_COUNT:    bin_count = data[8:0];
         blpe_pkg::CSR_RANGE_LOW:    range_low = data[16:0];
         blpe_pkg::CSR_BIN_SCALE:    bin_scale = data;
         blpe_pkg::CSR_NODATA_VALUE: nodata_value = data[16:0];
         blpe_pkg::CSR_NODATA_EN:    nodata_en = data[0];
         default: ;
      endcase
   endfunction

   function void predict_item(logic op, logic signed [16:0] sample, logic last,
                              logic [7:0] idx, logic signed [16:0] value);
      pixel_result_type   res;
      longint             diff;
      longint             bin;
      longint             count;
      if (op == blpe_pkg::OP_LUT_WRITE) begin
         lut_mem[idx] = value;
         return;
      end
      res.pixel = sample;
      res.eob   = last;
      if (!(nodata_en && sample == nodata_value)) begin
         if (mode == blpe_pkg::MODE_CLAMP) begin
            if (sample < 0)
               res.pixel = '0;
            else if (sample > blpe_pkg::CLAMP_MAX)
               res.pixel = 17'(blpe_pkg::CLAMP_MAX);
         end else if (sample >= range_low) begin
            diff  = longint'(sample) - longint'(range_low);
            bin   = (diff * longint'(bin_scale)) >> blpe_pkg::FRAC_W;
            count = longint'(bin_count);
            if (count == 0)
               count = 1;
            if (count > 256)
               count = 256;
            if (bin >= count)
               bin = count - 1;
            res.pixel = lut_mem[bin];
         end
      end
      pending_pixels.push_back(res);
   endfunction

   function void check_pixel(logic [16:0] pixel, logic eob);
      pixel_result_type want;
      if (pending_pixels.size() == 0) begin
         if (fault_count < 10)
            $display("unexpected pixel transfer: pixel_out %0d end_of_block %0b",
                     $signed(pixel), eob);
         fault_count++;
         return;
      end
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel || eob !== want.eob) begin
         if (fault_count < 10)
            $display("pixel mismatch: expected pixel_out %0d eob %0b, got %0d eob %0b",
                     $signed(want.pixel), want.eob, $signed(pixel), eob);
         fault_count++;
      end
   endfunction

   function int pending();
      return pending_pixels.size();
   endfunction
endclass

module tb;
   import blpe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int PHASE_ITEMS = 53;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = OP_PIXEL;
   logic signed [16:0] req_sample = '0;
   logic               req_last_pixel = 1'b0;
   logic [7:0]         req_lut_index = '0;
   logic signed [16:0] req_lut_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [16:0] rsp_pixel_out;
   logic               rsp_end_of_block;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_data = '0;

   int idle_pct  = 0;
   int stall_pct = 0;

   enhancer_scoreboard sb = new();

   binned_lut_pixel_enhancer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_sample       (req_sample),
      .req_last_pixel   (req_last_pixel),
      .req_lut_index    (req_lut_index),
      .req_lut_value    (req_lut_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_end_of_block (rsp_end_of_block),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.predict_item(req_op, req_sample, req_last_pixel, req_lut_index, req_lut_value);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel(rsp_pixel_out, rsp_end_of_block);
   end

   initial begin
      #5_000_000;
      $display("[binned_lut_pixel_enhancer] ERROR");
      $finish;
   end

   function automatic logic signed [16:0] any_value();
      return 17'(int'($urandom_range(98303)) - 32768);
   endfunction

   function automatic logic signed [16:0] pick_sample();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(98303)) - 32768;
         4, 5, 6:    v = int'(sb.range_low) + int'($urandom_range(2020)) - 20;
         7:          v = int'(sb.nodata_value);
         8:          v = $urandom_range(1) ? 65535 : -32768;
         default:    v = int'($urandom_range(300)) - 20;
      endcase
      if (v < -32768)
         v = -32768;
      if (v > 65535)
         v = 65535;
      return 17'(v);
   endfunction

   task automatic send_item(logic op, logic signed [16:0] s, logic last,
                            logic [7:0] idx, logic signed [16:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_sample     <= s;
      req_last_pixel <= last;
      req_lut_index  <= idx;
      req_lut_value  <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_pixel(logic signed [16:0] s, logic last);
      send_item(OP_PIXEL, s, last, 8'($urandom), any_value());
   endtask

   task automatic send_lut(logic [7:0] idx, logic signed [16:0] v);
      send_item(OP_LUT_WRITE, any_value(), 1'($urandom), idx, v);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_config(enh_cfg_type c);
      csr_write(CSR_MODE, 24'(c.mode));
      csr_write(CSR_BIN_COUNT, 24'(c.bin_cnt));
      csr_write(CSR_RANGE_LOW, {7'd0, c.low});
      csr_write(CSR_BIN_SCALE, c.scale);
      csr_write(CSR_NODATA_VALUE, {7'd0, c.nodata});
      csr_write(CSR_NODATA_EN, 24'(c.nodata_en));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 15)
            send_lut(8'($urandom), any_value());
         else
            send_pixel(pick_sample(), $urandom_range(7) == 0);
      end
      wait_idle();
   endtask

   initial begin
      enh_cfg_type cfg;
      enh_cfg_type plan [8];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      cfg = '{MODE_LUT, 9'd4, 17'sd0, 24'd65536, 17'sd7, 1'b1};
      apply_config(cfg);
      for (int i = 0; i < 256; i++)
         send_lut(8'(i), any_value());

      // directed: table extremes, binning edges, below range, no-data
      send_lut(8'd0, -17'sd32768);
      send_lut(8'd3, 17'sd65535);
      send_lut(8'd255, 17'sd0);
      send_pixel(17'sd0, 1'b0);
      send_pixel(17'sd3, 1'b0);
      send_pixel(17'sd100, 1'b0);
      send_pixel(17'sd65535, 1'b1);
      send_pixel(-17'sd1, 1'b0);
      send_pixel(-17'sd32768, 1'b0);
      send_pixel(17'sd7, 1'b1);
      wait_idle();

      cfg = '{MODE_CLAMP, 9'd256, 17'sd0, 24'd65536, -17'sd5, 1'b1};
      apply_config(cfg);
      send_pixel(-17'sd32768, 1'b0);
      send_pixel(-17'sd5, 1'b0);
      send_pixel(-17'sd1, 1'b0);
      send_pixel(17'sd0, 1'b0);
      send_pixel(17'sd255, 1'b0);
      send_pixel(17'sd256, 1'b0);
      send_pixel(17'sd65535, 1'b1);
      wait_idle();

      // undecoded register indexes must be dropped
      csr_write(CSR_SPARE_LO, 24'($urandom));
      csr_write(CSR_SPARE_HI, 24'hFFFFFF);
      csr_wr_en <= 1'b0;
      send_pixel(17'sd300, 1'b1);
      wait_idle();

      plan[0] = '{MODE_LUT,   9'd256, -17'sd32768, 24'd170,      17'sd100,    1'b1};
      plan[1] = '{MODE_LUT,   9'd16,  17'sd1000,   24'd491,      -17'sd32768, 1'b1};
      plan[2] = '{MODE_CLAMP, 9'd256, 17'sd0,      24'd65536,    17'sd65535,  1'b1};
      plan[3] = '{MODE_LUT,   9'd1,   17'sd65535,  24'hFFFFFF,   17'sd0,      1'b0};
      plan[4] = '{MODE_LUT,   9'd0,   17'sd0,      24'd0,        -17'sd1,     1'b1};
      plan[5] = '{MODE_LUT,   9'd511, -17'sd100,   24'hFFFFFF,   17'sd0,      1'b0};
      plan[6] = '{MODE_CLAMP, 9'd256, 17'sd0,      24'd65536,    17'sd0,      1'b0};
      plan[7].mode      = 1'($urandom);
      plan[7].bin_cnt   = 9'($urandom);
      plan[7].low       = any_value();
      plan[7].scale     = 24'($urandom);
      plan[7].nodata    = any_value();
      plan[7].nodata_en = 1'($urandom);

      for (int p = 0; p < 8; p++) begin
         apply_config(plan[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         run_phase(PHASE_ITEMS);
      end

      sb.fault_count += sb.pending();
      if (sb.fault_count == 0)
         $display("[binned_lut_pixel_enhancer] OK");
      else
         $display("[binned_lut_pixel_enhancer] ERROR");
      $finish;
   end
endmodule

### binned_lut_pixel_enhancer.f
+incdir+rtl/core
rtl/core/blpe_pkg.sv
rtl/core/blpe_ram.sv
rtl/core/binned_lut_pixel_enhancer.sv
rtl/core/blpe_checker.sv
sim/tb.sv
